/* hdl/rmlm_pkg.sv */
// ----------------------------------------------------------------------------
// rmlm_pkg
// shared types and constants of the recursive mutex lock manager
// ----------------------------------------------------------------------------
package rmlm_pkg;

  localparam int NUM_LOCKS = 32;
  localparam int NUM_TASKS = 16;
  localparam int PRIO_W    = 5;
  localparam int LOCK_W    = 5;
  localparam int TASK_W    = 4;
  localparam int HOLD_W    = 8;
  localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;

  typedef enum logic [2:0] {
    K_CREATE = 3'd0,
    K_DELETE = 3'd1,
    K_LOCK   = 3'd2,
    K_TRY    = 3'd3,
    K_UNLOCK = 3'd4,
    K_CANCEL = 3'd5,
    K_RSV6   = 3'd6,
    K_RSV7   = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_BAD_ID   = 4'd1,
    ST_BUSY     = 4'd2,
    ST_NOT_OWN  = 4'd3,
    ST_TIMEOUT  = 4'd4,
    ST_IN_IRQ   = 4'd5,
    ST_DEADLOCK = 4'd6,
    ST_BLOCKED  = 4'd7,
    ST_NO_FREE  = 4'd8,
    ST_DELETED  = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    EV_REPLY = 2'd0,
    EV_WAKE  = 2'd1,
    EV_SETP  = 2'd2
  } event_e;

  typedef struct packed {
    logic              in_use;
    logic [TASK_W-1:0] owner;
    logic [HOLD_W-1:0] hold;
    logic [NUM_TASKS-1:0] waiter;
  } lock_entry_t;

  typedef struct packed {
    logic              we;
    logic [LOCK_W-1:0] addr;
    lock_entry_t       entry;
  } lock_wr_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic              blk_v;
    logic [LOCK_W-1:0] blk_lock;
  } task_entry_t;

  typedef struct packed {
    logic              tp_we;
    logic [TASK_W-1:0] tp_addr;
    logic [PRIO_W-1:0] tp_data;
    logic              blk_we;
    logic [TASK_W-1:0] blk_addr;
    logic              blk_v;
    logic [LOCK_W-1:0] blk_lock;
  } task_wr_t;

endpackage

/* hdl/recursive_mutex_lock_manager_unit.sv */
// ----------------------------------------------------------------------------
// recursive_mutex_lock_manager_unit
// lock manager for a pool of recursive mutexes with priority inheritance
// ----------------------------------------------------------------------------
// requests enter on the s_axis channel (kind in tuser), one at a time; the
// input is ready only while the sequencer is idle. each request produces one
// or more results on m_axis: wake and set-priority events first, then the
// reply to the caller, marked by tlast.
// create, trylock, cancel and plain lock/unlock pass the eval and reply states.
// a contended lock walks the owner chain one hop per cycle when deadlock
// checking is on, and queues the caller in states block, blk2 and blk3.
// an unlock that releases the mutex scans all 16 tasks, one per cycle, with
// one priority compare for the restore value and one for the best waiter.
// delete visits all 16 tasks, one per cycle unless a wake event is held.
// each emitted result holds the sequencer until the output register is free,
// so a stalled receiver stalls the request in flight and the input.
// reset clears the mutex pool, owners, counts, waiter sets and blocked marks
// and sets both configuration bits to 1; no clearing pass is needed.
// configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i.
// ----------------------------------------------------------------------------
module recursive_mutex_lock_manager_unit import rmlm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // lock_index, requester, requester_priority, requester_base_priority,
  // may_wait, in_interrupt
  input  logic [23:0] s_axis_tdata,
  // kind
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, result_lock, target_task, new_priority
  output logic [23:0] m_axis_tdata,
  // event_res
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_EVAL  = 11'b00000000010,
    S_WALK  = 11'b00000000100,
    S_BLOCK = 11'b00000001000,
    S_BLK2  = 11'b00000010000,
    S_BLK3  = 11'b00000100000,
    S_SCAN  = 11'b00001000000,
    S_REST  = 11'b00010000000,
    S_WAKE  = 11'b00100000000,
    S_DEL   = 11'b01000000000,
    S_REPLY = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic inherit_q, dlchk_q;

  kind_e             kind_q;
  logic [LOCK_W-1:0] idx_q, rl_q, rl_d;
  logic [TASK_W-1:0] req_q, cnt_q, cnt_d, cur_q, cur_d, best_q, best_d;
  logic [PRIO_W-1:0] prio_q, base_q, np_q, np_d, bestp_q, bestp_d;
  logic              mw_q, irq_q, bestv_q, bestv_d;
  status_e           st_q, st_d;
  logic [NUM_TASKS-1:0] wset_q, wset_d;

  logic [LOCK_W-1:0] la;
  logic [TASK_W-1:0] ta;
  lock_entry_t       lrd;
  lock_wr_t          lw;
  task_entry_t       trd;
  task_wr_t          tw;
  logic [NUM_LOCKS-1:0] in_use_map;

  logic              ff_found;
  logic [LOCK_W-1:0] ff_idx;

  logic              ovld_q;
  event_e            oev_q, em_ev;
  status_e           ost_q, em_st;
  logic [LOCK_W-1:0] orl_q, em_rl;
  logic [TASK_W-1:0] ott_q, em_tt;
  logic [PRIO_W-1:0] onp_q, em_np;
  logic              olast_q, em_last, em_req, can_emit;

  logic              acc;
  logic              prio_less;
  logic [PRIO_W-1:0] cmp_a, cmp_b;
  logic              cnt_end;

  rmlm_lock_table u_lock (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_addr_i    (la),
    .rd_o         (lrd),
    .in_use_map_o (in_use_map),
    .wr_i         (lw)
  );

  rmlm_task_table u_task (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (ta),
    .rd_o      (trd),
    .wr_i      (tw)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !ovld_q || m_axis_tready;
  assign cnt_end       = (cnt_q == TASK_W'(NUM_TASKS - 1));

  // shared priority compare
  assign prio_less = (cmp_a < cmp_b);

  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
      if (!in_use_map[i]) begin
        ff_found = 1'b1;
        ff_idx   = LOCK_W'(i);
      end
    end
  end

  // read address selection
  always_comb begin
    la = idx_q;
    ta = req_q;
    unique case (state_q)
      S_WALK: begin
        ta = cur_q;
        la = trd.blk_lock;
      end
      S_BLOCK: ta = lrd.owner;
      S_BLK2:  la = trd.blk_lock;
      S_SCAN: begin
        ta = cnt_q;
        la = trd.blk_lock;
      end
      S_DEL:   ta = cnt_q;
      S_IDLE, S_EVAL, S_BLK3, S_REST, S_WAKE, S_REPLY: ;
      default: ;
    endcase
  end

  always_comb begin
    logic cand;
    state_d = state_q;
    st_d    = st_q;
    rl_d    = rl_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    np_d    = np_q;
    best_d  = best_q;
    bestp_d = bestp_q;
    bestv_d = bestv_q;
    wset_d  = wset_q;
    lw       = '0;
    lw.addr  = la;
    lw.entry = lrd;
    tw       = '0;
    em_req  = 1'b0;
    em_ev   = EV_REPLY;
    em_st   = ST_OK;
    em_rl   = idx_q;
    em_tt   = req_q;
    em_np   = '0;
    em_last = 1'b0;
    cmp_a   = prio_q;
    cmp_b   = trd.prio;
    cand    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          rl_d = s_axis_tdata[4:0];
          st_d = ST_OK;
          if (s_axis_tuser > 3'(K_CANCEL)) begin
            st_d    = ST_BAD_ID;
            state_d = S_REPLY;
          end else begin
            tw.tp_we   = 1'b1;
            tw.tp_addr = s_axis_tdata[8:5];
            tw.tp_data = s_axis_tdata[13:9];
            state_d    = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        state_d = S_REPLY;
        if (kind_q == K_CREATE) begin
          if (ff_found) begin
            lw.we    = 1'b1;
            lw.addr  = ff_idx;
            lw.entry = '{in_use: 1'b1, owner: '0, hold: '0, waiter: '0};
            rl_d     = ff_idx;
          end else begin
            st_d = ST_NO_FREE;
            rl_d = '0;
          end
        end else if (!lrd.in_use) begin
          st_d = ST_BAD_ID;
        end else begin
          unique case (kind_q)
            K_DELETE: begin
              if (lrd.hold != '0) begin
                st_d = ST_BUSY;
              end else begin
                wset_d  = lrd.waiter;
                cnt_d   = '0;
                state_d = S_DEL;
              end
            end
            K_LOCK, K_TRY: begin
              if (lrd.hold == '0) begin
                lw.we          = 1'b1;
                lw.entry.owner = req_q;
                lw.entry.hold  = HOLD_W'(1);
              end else if (lrd.owner == req_q) begin
                if (lrd.hold >= HOLD_MAX) begin
                  st_d = ST_BUSY;
                end else begin
                  lw.we         = 1'b1;
                  lw.entry.hold = lrd.hold + HOLD_W'(1);
                end
              end else if (kind_q == K_TRY) begin
                st_d = ST_BUSY;
              end else if (!mw_q) begin
                st_d = ST_TIMEOUT;
              end else if (irq_q) begin
                st_d = ST_IN_IRQ;
              end else if (dlchk_q) begin
                cur_d   = lrd.owner;
                cnt_d   = '0;
                state_d = S_WALK;
              end else begin
                state_d = S_BLOCK;
              end
            end
            K_UNLOCK: begin
              if (lrd.hold == '0 || lrd.owner != req_q) begin
                st_d = ST_NOT_OWN;
              end else begin
                lw.we         = 1'b1;
                lw.entry.hold = lrd.hold - HOLD_W'(1);
                if (lrd.hold == HOLD_W'(1)) begin
                  wset_d  = lrd.waiter;
                  np_d    = base_q;
                  bestv_d = 1'b0;
                  cnt_d   = '0;
                  state_d = S_SCAN;
                end
              end
            end
            K_CANCEL: begin
              if (trd.blk_v && trd.blk_lock == idx_q && lrd.waiter[req_q]) begin
                lw.we           = 1'b1;
                lw.entry.waiter = lrd.waiter & ~(NUM_TASKS'(1) << req_q);
                tw.blk_we       = 1'b1;
                tw.blk_addr     = req_q;
                st_d            = ST_TIMEOUT;
              end
            end
            default: st_d = ST_BAD_ID;
          endcase
        end
      end
      S_WALK: begin
        if (cur_q == req_q) begin
          st_d    = ST_DEADLOCK;
          state_d = S_REPLY;
        end else if (!trd.blk_v || lrd.hold == '0 || cnt_end) begin
          state_d = S_BLOCK;
        end else begin
          cur_d = lrd.owner;
          cnt_d = cnt_q + TASK_W'(1);
        end
      end
      S_BLOCK: begin
        if (inherit_q && prio_less) begin
          em_req = 1'b1;
          em_ev  = EV_SETP;
          em_tt  = lrd.owner;
          em_np  = prio_q;
          if (can_emit) begin
            tw.tp_we   = 1'b1;
            tw.tp_addr = lrd.owner;
            tw.tp_data = prio_q;
            state_d    = S_BLK2;
          end
        end else begin
          state_d = S_BLK2;
        end
      end
      S_BLK2: begin
        if (trd.blk_v) begin
          lw.we           = 1'b1;
          lw.entry.waiter = lrd.waiter & ~(NUM_TASKS'(1) << req_q);
        end
        state_d = S_BLK3;
      end
      S_BLK3: begin
        lw.we           = 1'b1;
        lw.entry.waiter = lrd.waiter | (NUM_TASKS'(1) << req_q);
        tw.blk_we       = 1'b1;
        tw.blk_addr     = req_q;
        tw.blk_v        = 1'b1;
        tw.blk_lock     = idx_q;
        st_d            = ST_BLOCKED;
        state_d         = S_REPLY;
      end
      S_SCAN: begin
        cand = trd.blk_v && trd.blk_lock != idx_q && lrd.hold != '0 &&
               lrd.owner == req_q && lrd.waiter[cnt_q];
        cmp_a = trd.prio;
        cmp_b = np_q;
        if (cand && prio_less) begin
          np_d = trd.prio;
        end
        if (wset_q[cnt_q] && (!bestv_q || trd.prio < bestp_q)) begin
          bestv_d = 1'b1;
          best_d  = cnt_q;
          bestp_d = trd.prio;
        end
        cnt_d = cnt_q + TASK_W'(1);
        if (cnt_end) begin
          state_d = S_REST;
        end
      end
      S_REST: begin
        if (inherit_q && np_q != trd.prio) begin
          em_req = 1'b1;
          em_ev  = EV_SETP;
          em_np  = np_q;
          if (can_emit) begin
            tw.tp_we   = 1'b1;
            tw.tp_addr = req_q;
            tw.tp_data = np_q;
            state_d    = S_WAKE;
          end
        end else begin
          state_d = S_WAKE;
        end
      end
      S_WAKE: begin
        if (bestv_q) begin
          em_req = 1'b1;
          em_ev  = EV_WAKE;
          em_tt  = best_q;
          if (can_emit) begin
            lw.we           = 1'b1;
            lw.entry.owner  = best_q;
            lw.entry.hold   = HOLD_W'(1);
            lw.entry.waiter = wset_q & ~(NUM_TASKS'(1) << best_q);
            tw.blk_we       = 1'b1;
            tw.blk_addr     = best_q;
            state_d         = S_REPLY;
          end
        end else begin
          state_d = S_REPLY;
        end
      end
      S_DEL: begin
        em_req = wset_q[cnt_q];
        em_ev  = EV_WAKE;
        em_st  = ST_DELETED;
        em_tt  = cnt_q;
        if (!wset_q[cnt_q] || can_emit) begin
          tw.blk_we   = wset_q[cnt_q];
          tw.blk_addr = cnt_q;
          cnt_d       = cnt_q + TASK_W'(1);
          if (cnt_end) begin
            lw.we   = 1'b1;
            lw.entry = '{in_use: 1'b0, owner: '0, hold: '0, waiter: '0};
            state_d = S_REPLY;
          end
        end
      end
      S_REPLY: begin
        em_req  = 1'b1;
        em_st   = st_q;
        em_rl   = rl_q;
        em_last = 1'b1;
        if (can_emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      inherit_q <= 1'b1;
      dlchk_q   <= 1'b1;
      ovld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i) begin
          dlchk_q <= cfg_data_i;
        end else begin
          inherit_q <= cfg_data_i;
        end
      end
      if (em_req && can_emit) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      kind_q <= kind_e'(s_axis_tuser);
      idx_q  <= s_axis_tdata[4:0];
      req_q  <= s_axis_tdata[8:5];
      prio_q <= s_axis_tdata[13:9];
      base_q <= s_axis_tdata[18:14];
      mw_q   <= s_axis_tdata[19];
      irq_q  <= s_axis_tdata[20];
    end
    st_q    <= st_d;
    rl_q    <= rl_d;
    cnt_q   <= cnt_d;
    cur_q   <= cur_d;
    np_q    <= np_d;
    best_q  <= best_d;
    bestp_q <= bestp_d;
    bestv_q <= bestv_d;
    wset_q  <= wset_d;
    if (em_req && can_emit) begin
      oev_q   <= em_ev;
      ost_q   <= em_st;
      orl_q   <= em_rl;
      ott_q   <= em_tt;
      onp_q   <= em_np;
      olast_q <= em_last;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tuser  = oev_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {6'd0, onp_q, ott_q, orl_q, ost_q};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_free_unheld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lrd.in_use |-> lrd.hold == '0)
    else $error("free mutex with nonzero hold count");

  a_walk_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> dlchk_q)
    else $error("owner chain walk with deadlock check off");

endmodule

/* hdl/rmlm_lock_table.sv */
// ----------------------------------------------------------------------------
// rmlm_lock_table
// per-mutex state: in-use map, owner, recursion count and waiter set
// ----------------------------------------------------------------------------
module rmlm_lock_table import rmlm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [LOCK_W-1:0]    rd_addr_i,
  output lock_entry_t          rd_o,
  output logic [NUM_LOCKS-1:0] in_use_map_o,
  input  lock_wr_t             wr_i
);

  logic [NUM_LOCKS-1:0] in_use_q;
  logic [TASK_W-1:0]    owner_q  [NUM_LOCKS];
  logic [HOLD_W-1:0]    hold_q   [NUM_LOCKS];
  logic [NUM_TASKS-1:0] waiter_q [NUM_LOCKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
        owner_q[i]  <= '0;
        hold_q[i]   <= '0;
        waiter_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      in_use_q[wr_i.addr] <= wr_i.entry.in_use;
      owner_q[wr_i.addr]  <= wr_i.entry.owner;
      hold_q[wr_i.addr]   <= wr_i.entry.hold;
      waiter_q[wr_i.addr] <= wr_i.entry.waiter;
    end
  end

  assign rd_o.in_use  = in_use_q[rd_addr_i];
  assign rd_o.owner   = owner_q[rd_addr_i];
  assign rd_o.hold    = hold_q[rd_addr_i];
  assign rd_o.waiter  = waiter_q[rd_addr_i];
  assign in_use_map_o = in_use_q;

endmodule

/* hdl/rmlm_task_table.sv */
// ----------------------------------------------------------------------------
// rmlm_task_table
// per-task state: recorded priority and blocked-on mutex
// ----------------------------------------------------------------------------
module rmlm_task_table import rmlm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TASK_W-1:0] rd_addr_i,
  output task_entry_t       rd_o,
  input  task_wr_t          wr_i
);

  logic [PRIO_W-1:0] tp_q    [NUM_TASKS];
  logic              blkv_q  [NUM_TASKS];
  logic [LOCK_W-1:0] blkl_q  [NUM_TASKS];

  always_ff @(posedge clk_i) begin
    if (wr_i.tp_we) begin
      tp_q[wr_i.tp_addr] <= wr_i.tp_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        blkv_q[t] <= 1'b0;
        blkl_q[t] <= '0;
      end
    end else if (wr_i.blk_we) begin
      blkv_q[wr_i.blk_addr] <= wr_i.blk_v;
      blkl_q[wr_i.blk_addr] <= wr_i.blk_lock;
    end
  end

  assign rd_o.prio     = tp_q[rd_addr_i];
  assign rd_o.blk_v    = blkv_q[rd_addr_i];
  assign rd_o.blk_lock = blkl_q[rd_addr_i];

endmodule
